// ----- rtl/pbts_pkg.sv -----
// Package for the priority bitmap task scheduler: sizes, operation codes,
// payload structs and the front-to-back command struct. No dependencies.
package pbts_pkg;

   localparam int PRIORITY_LEVELS = 32;
   localparam int MAX_TASKS       = 64;
   localparam int TASK_W          = 6;
   localparam int LEVEL_W         = 5;
   localparam int TIME_W          = 64;
   localparam int CNT_W           = 7;
   localparam int QDEPTH          = 2;

   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_PICK    = 2'd1;
   localparam logic [1:0] FUNC_SLEEP   = 2'd2;
   localparam logic [1:0] FUNC_TICK    = 2'd3;

   typedef struct packed {
      logic [1:0]          func;
      logic [TASK_W-1:0]   task_id;
      logic [7:0]          priority_req;
      logic [TIME_W-1:0]   wake_time;
      logic [TIME_W-1:0]   now;
   } req_type;

   typedef struct packed {
      logic [TASK_W-1:0]          selected_task;
      logic                       was_idle;
      logic [CNT_W-1:0]           woken_count;
      logic [PRIORITY_LEVELS-1:0] nonempty_levels;
   } rsp_type;

   // Classified command handed from the front part to the back part.
   typedef struct packed {
      logic [1:0]          func;
      logic [TASK_W-1:0]   task_id;
      logic [LEVEL_W-1:0]  level;
      logic [TIME_W-1:0]   wake_time;
      logic [TIME_W-1:0]   now;
   } cmd_type;

endpackage

// ----- rtl/pbts_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pbts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/pbts_front.sv -----
// Front part: takes request transactions, clamps the priority and pushes
// classified commands into a short queue. Depends on pbts_pkg.
module pbts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbts_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output pbts_pkg::cmd_type cmd_data
);
   import pbts_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);

   cmd_type          q_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;
   logic             push;
   cmd_type          cmd_in;

   assign req_stall = (count_ff == (PTR_W+1)'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      cmd_in.func      = req_data.func;
      cmd_in.task_id   = req_data.task_id;
      cmd_in.level     = (req_data.priority_req >= 8'(PRIORITY_LEVELS)) ?
                         LEVEL_W'(PRIORITY_LEVELS-1) : req_data.priority_req[LEVEL_W-1:0];
      cmd_in.wake_time = req_data.wake_time;
      cmd_in.now       = req_data.now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_pop);
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end
endmodule

// ----- rtl/pbts_back.sv -----
// Back part: sequencer that owns the ready queues, level bitmap and sleep
// list and executes one command at a time. Depends on pbts_pkg, pbts_ram.
module pbts_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [5:0]        idle_task,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  pbts_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbts_pkg::rsp_type rsp_data
);
   import pbts_pkg::*;

   localparam int L = PRIORITY_LEVELS;
   localparam int T = MAX_TASKS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EXEC, ST_TK_READ, ST_TK_EVAL, ST_PUSH, ST_DONE
   } state_type;

   state_type            state_ff;
   cmd_type              cmd_ff;
   logic [T-1:0]         qnext_nil_ff;
   logic [TASK_W-1:0]    head_ff [L];
   logic [TASK_W-1:0]    tail_ff [L];
   logic [L-1:0]         bitmap_ff;
   logic [T-1:0]         snext_nil_ff;
   logic [TASK_W-1:0]    shead_ff;
   logic                 shead_nil_ff;
   logic [T-1:0]         in_ready_ff;
   logic [T-1:0]         in_sleep_ff;
   logic [TASK_W-1:0]    cur_ff, prev_ff;
   logic                 prev_nil_ff;
   logic [TASK_W-1:0]    push_task_ff;
   logic [CNT_W-1:0]     woken_ff;
   logic [CNT_W-1:0]     steps_ff;
   logic [TASK_W-1:0]    sel_ff;
   logic                 was_idle_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   // Per-task level, wake time and both next links live in RAMs.
   logic                 lvl_we;
   logic [LEVEL_W-1:0]   lvl_rd;
   logic [TASK_W-1:0]    lvl_raddr;
   logic                 wt_we;
   logic [TIME_W-1:0]    wt_rd;
   logic                 wake_now;
   logic                 sn_we;
   logic [TASK_W-1:0]    sn_waddr;
   logic [TASK_W-1:0]    sn_wdata;
   logic [TASK_W-1:0]    sn_rd;
   logic                 qn_we;
   logic [TASK_W-1:0]    qn_waddr;
   logic [TASK_W-1:0]    qn_wdata;
   logic [TASK_W-1:0]    qn_raddr;
   logic [TASK_W-1:0]    qn_rd;

   assign lvl_we = (state_ff == ST_EXEC) && (cmd_ff.func == FUNC_ENQUEUE) &&
                   !in_ready_ff[cmd_ff.task_id];
   assign wt_we  = (state_ff == ST_EXEC) && (cmd_ff.func == FUNC_SLEEP) &&
                   !in_sleep_ff[cmd_ff.task_id];
   assign lvl_raddr = cur_ff;
   assign wake_now  = (wt_rd <= cmd_ff.now);

   pbts_ram #(.WIDTH(LEVEL_W), .DEPTH(T)) u_level_ram (
      .clock(clock), .wr_en(lvl_we), .wr_addr(cmd_ff.task_id),
      .wr_data(cmd_ff.level), .rd_addr(lvl_raddr), .rd_data(lvl_rd));

   pbts_ram #(.WIDTH(TIME_W), .DEPTH(T)) u_wake_ram (
      .clock(clock), .wr_en(wt_we), .wr_addr(cmd_ff.task_id),
      .wr_data(cmd_ff.wake_time), .rd_addr(cur_ff), .rd_data(wt_rd));

   // Sleep links: sleep pushes at the head, a wake unlinks the current
   // sleeper from its predecessor. Reads follow cur_ff like the level and wake-time RAMs.
   assign sn_we    = ((state_ff == ST_EXEC) && (cmd_ff.func == FUNC_SLEEP) &&
                      !in_sleep_ff[cmd_ff.task_id]) ||
                     ((state_ff == ST_TK_EVAL) && wake_now && !prev_nil_ff);
   assign sn_waddr = (state_ff == ST_EXEC) ? cmd_ff.task_id : prev_ff;
   assign sn_wdata = (state_ff == ST_EXEC) ? shead_ff : sn_rd;

   pbts_ram #(.WIDTH(TASK_W), .DEPTH(T)) u_snext_ram (
      .clock(clock), .wr_en(sn_we), .wr_addr(sn_waddr),
      .wr_data(sn_wdata), .rd_addr(cur_ff), .rd_data(sn_rd));

   // Lowest set bit of the bitmap.
   logic [LEVEL_W-1:0] first_lvl;
   always_comb begin
      first_lvl = '0;
      for (int i = L-1; i >= 0; i--) begin
         if (bitmap_ff[i]) begin
            first_lvl = LEVEL_W'(i);
         end
      end
   end

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Append a task to the tail of a level (caller checks in_ready).
   logic [LEVEL_W-1:0] push_lvl;
   assign push_lvl = (state_ff == ST_PUSH) ? lvl_rd : cmd_ff.level;

   // Ready links. The head of the first level is read during the idle
   // cycle, so its next link is ready when a pick executes.
   assign qn_we    = bitmap_ff[push_lvl] &&
                     (((state_ff == ST_EXEC) && (cmd_ff.func == FUNC_ENQUEUE) &&
                       !in_ready_ff[cmd_ff.task_id]) ||
                      ((state_ff == ST_PUSH) && !in_ready_ff[push_task_ff]));
   assign qn_waddr = tail_ff[push_lvl];
   assign qn_wdata = (state_ff == ST_PUSH) ? push_task_ff : cmd_ff.task_id;
   assign qn_raddr = head_ff[first_lvl];

   pbts_ram #(.WIDTH(TASK_W), .DEPTH(T)) u_qnext_ram (
      .clock(clock), .wr_en(qn_we), .wr_addr(qn_waddr),
      .wr_data(qn_wdata), .rd_addr(qn_raddr), .rd_data(qn_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qnext_nil_ff <= '1;
         snext_nil_ff <= '1;
         bitmap_ff    <= '0;
         shead_nil_ff <= 1'b1;
         in_ready_ff  <= '0;
         in_sleep_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff      <= cmd_data;
                  sel_ff      <= '0;
                  was_idle_ff <= 1'b0;
                  woken_ff    <= '0;
                  steps_ff    <= '0;
                  state_ff    <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (cmd_ff.func)
                  FUNC_ENQUEUE: begin
                     if (!in_ready_ff[cmd_ff.task_id]) begin
                        qnext_nil_ff[cmd_ff.task_id] <= 1'b1;
                        if (bitmap_ff[push_lvl]) begin
                           qnext_nil_ff[tail_ff[push_lvl]] <= 1'b0;
                        end else begin
                           head_ff[push_lvl] <= cmd_ff.task_id;
                        end
                        tail_ff[push_lvl]            <= cmd_ff.task_id;
                        bitmap_ff[push_lvl]          <= 1'b1;
                        in_ready_ff[cmd_ff.task_id]  <= 1'b1;
                     end
                     state_ff <= ST_DONE;
                  end
                  FUNC_PICK: begin
                     if (bitmap_ff == '0) begin
                        sel_ff      <= idle_task;
                        was_idle_ff <= 1'b1;
                     end else begin
                        sel_ff <= head_ff[first_lvl];
                        in_ready_ff[head_ff[first_lvl]]  <= 1'b0;
                        qnext_nil_ff[head_ff[first_lvl]] <= 1'b1;
                        if (qnext_nil_ff[head_ff[first_lvl]]) begin
                           bitmap_ff[first_lvl] <= 1'b0;
                        end else begin
                           head_ff[first_lvl] <= qn_rd;
                        end
                     end
                     state_ff <= ST_DONE;
                  end
                  FUNC_SLEEP: begin
                     if (!in_sleep_ff[cmd_ff.task_id]) begin
                        snext_nil_ff[cmd_ff.task_id] <= shead_nil_ff;
                        shead_ff                     <= cmd_ff.task_id;
                        shead_nil_ff                 <= 1'b0;
                        in_sleep_ff[cmd_ff.task_id]  <= 1'b1;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: begin
                     cur_ff      <= shead_ff;
                     prev_nil_ff <= 1'b1;
                     state_ff    <= shead_nil_ff ? ST_DONE : ST_TK_READ;
                  end
               endcase
            end
            ST_TK_READ: begin
               // RAM read of the current sleeper is in flight.
               state_ff <= ST_TK_EVAL;
            end
            ST_TK_EVAL: begin
               steps_ff <= steps_ff + 1'b1;
               if (wake_now) begin
                  if (prev_nil_ff) begin
                     shead_ff     <= sn_rd;
                     shead_nil_ff <= snext_nil_ff[cur_ff];
                  end else begin
                     snext_nil_ff[prev_ff] <= snext_nil_ff[cur_ff];
                  end
                  in_sleep_ff[cur_ff]  <= 1'b0;
                  woken_ff             <= woken_ff + 1'b1;
                  push_task_ff         <= cur_ff;
                  state_ff             <= ST_PUSH;
               end else begin
                  prev_ff     <= cur_ff;
                  prev_nil_ff <= 1'b0;
                  cur_ff      <= sn_rd;
                  state_ff    <= (snext_nil_ff[cur_ff] ||
                                  steps_ff == CNT_W'(T-1)) ? ST_DONE : ST_TK_READ;
               end
            end
            ST_PUSH: begin
               // lvl_rd still holds the level of push_task_ff (cur_ff unchanged).
               if (!in_ready_ff[push_task_ff]) begin
                  qnext_nil_ff[push_task_ff] <= 1'b1;
                  if (bitmap_ff[push_lvl]) begin
                     qnext_nil_ff[tail_ff[push_lvl]] <= 1'b0;
                  end else begin
                     head_ff[push_lvl] <= push_task_ff;
                  end
                  tail_ff[push_lvl]         <= push_task_ff;
                  bitmap_ff[push_lvl]       <= 1'b1;
                  in_ready_ff[push_task_ff] <= 1'b1;
               end
               // The woken task's old link decides where the walk goes next.
               snext_nil_ff[push_task_ff] <= 1'b1;
               cur_ff   <= sn_rd;
               state_ff <= (snext_nil_ff[push_task_ff] || steps_ff == CNT_W'(T))
                           ? ST_DONE : ST_TK_READ;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_ff.selected_task   <= sel_ff;
                  rsp_ff.was_idle        <= was_idle_ff;
                  rsp_ff.woken_count     <= woken_ff;
                  rsp_ff.nonempty_levels <= bitmap_ff;
                  rsp_valid_ff           <= 1'b1;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/priority_bitmap_task_scheduler.sv -----
// Top level of the priority bitmap task scheduler: front part, command
// queue and back sequencer. Depends on pbts_pkg, pbts_front, pbts_back.
//
// Each request transaction yields exactly one response transaction. In the
// back sequencer, enqueue, pick next and sleep pass through the execute and
// done states; a tick walks the sleep list through read, evaluate and push
// states, because every sleeper's wake time, level and next link are read
// from RAM with a registered port. A two-entry command queue lets the front
// accept new transactions while the back is busy, and the response register
// holds a finished result while the next command starts. The idle_task
// register is written through csr_wr_en/csr_wr_data and should be written
// only when the block is quiet. Memories need no clearing pass after reset.
module priority_bitmap_task_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbts_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);
   import pbts_pkg::*;

   logic [5:0] idle_task_ff;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_task_ff <= '0;
      end else if (csr_wr_en) begin
         idle_task_ff <= csr_wr_data;
      end
   end

   pbts_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_pop, .cmd_data);

   pbts_back u_back (
      .clock, .reset, .idle_task(idle_task_ff), .cmd_valid, .cmd_pop, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data);

   // A popped command always comes from a nonempty queue.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("command popped from empty queue");

   // Idle pick responses carry no woken count.
   a_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.was_idle) |-> (rsp_data.woken_count == '0))
      else $error("idle response with woken tasks");
endmodule
